// ===== rtl/brute_force_nearest_neighbor_unit_defines.svh =====
// Assertion macros shared by the nearest neighbor unit modules
`ifndef BRUTE_FORCE_NEAREST_NEIGHBOR_UNIT_DEFINES_SVH
`define BRUTE_FORCE_NEAREST_NEIGHBOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFNN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BFNN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfnn_pkg.sv =====
// Shared constants and types of the nearest neighbor unit
package bfnn_pkg;

  // fixed field widths
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int FIELD_W = 16;
  localparam int DIST_W  = 34;

  // parameter defaults
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // func codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // operation carried through the queue
  localparam int OP_W = 2;
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_EMPTY = 2'd2
  } op_e;

endpackage

// ===== rtl/brute_force_nearest_neighbor_unit.sv =====
// Top level of the brute force 3-D nearest neighbor search unit
//
//   channel   ports                                              handshake
//   --------  -------------------------------------------------  ----------------------
//   config    cfg_we_i, cfg_wdata_i                              write on cfg_we_i
//   command   func_i, point_index_i, coord_x/y/z_i               start_i && !busy_o
//   result    found_o, neighbor_index_o, squared_distance_o      done_o, one cycle
//
// A point write leaves the scan engine idle. A query holds it for a scan whose length is
// set by the one store read port that the scan walks a point per cycle; the result is
// registered once the compare pipeline has drained.
// Queries past the count, or with fewer than two points, skip the scan and answer from idle.
// A two-word queue sits in front of the engine; busy_o is high only while it is full.
// Reset clears the count register and control state; the point store comes up unknown.
module brute_force_nearest_neighbor_unit #(
  parameter int MAX_POINTS = bfnn_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = bfnn_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfnn_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                func_i,
  input  logic [bfnn_pkg::IDX_W-1:0]          point_index_i,
  input  logic signed [bfnn_pkg::FIELD_W-1:0] coord_x_i,
  input  logic signed [bfnn_pkg::FIELD_W-1:0] coord_y_i,
  input  logic signed [bfnn_pkg::FIELD_W-1:0] coord_z_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic [bfnn_pkg::IDX_W-1:0]          neighbor_index_o,
  output logic [bfnn_pkg::DIST_W-1:0]         squared_distance_o
);

  localparam int AW      = $clog2(MAX_POINTS);
  localparam int CW      = $clog2(MAX_POINTS + 1);
  localparam int ENTRY_W = bfnn_pkg::OP_W + AW + CW + 3 * COORD_BITS;

  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] head;

  assign busy_o = full;

  bfnn_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .CW         (CW),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .func_i        (func_i),
    .point_index_i (point_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (entry)
  );

  bfnn_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (bfnn_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  bfnn_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .CW         (CW),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .empty_i            (empty),
    .pop_o              (pop),
    .done_o             (done_o),
    .found_o            (found_o),
    .neighbor_index_o   (neighbor_index_o),
    .squared_distance_o (squared_distance_o)
  );

endmodule

// ===== rtl/bfnn_fifo.sv =====
// Small command queue decoupling the front from the scan engine
`include "brute_force_nearest_neighbor_unit_defines.svh"

module bfnn_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] head_o,
  output logic              empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BFNN_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `BFNN_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")

endmodule

// ===== rtl/bfnn_front.sv =====
// Front end: takes command words, holds the count register, classifies
module bfnn_front #(
  parameter int MAX_POINTS = bfnn_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = bfnn_pkg::COORD_BITS_DEF,
  parameter int AW         = $clog2(MAX_POINTS),
  parameter int CW         = $clog2(MAX_POINTS + 1),
  parameter int ENTRY_W    = bfnn_pkg::OP_W + AW + CW + 3 * COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfnn_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              start_i,
  input  logic                              func_i,
  input  logic [bfnn_pkg::IDX_W-1:0]        point_index_i,
  input  logic signed [bfnn_pkg::FIELD_W-1:0] coord_x_i,
  input  logic signed [bfnn_pkg::FIELD_W-1:0] coord_y_i,
  input  logic signed [bfnn_pkg::FIELD_W-1:0] coord_z_i,
  input  logic                              full_i,
  output logic                              push_o,
  output logic [ENTRY_W-1:0]                entry_o
);

  localparam int XW = (CW > bfnn_pkg::CNT_W) ? CW : bfnn_pkg::CNT_W;
  localparam logic [XW-1:0] MaxX = XW'(MAX_POINTS);

  logic [bfnn_pkg::CNT_W-1:0] point_count_q;
  logic [XW-1:0]              count_eff;
  logic [XW-1:0]              idx_x;
  logic                       wr_ok;
  logic                       q_ok;
  bfnn_pkg::op_e              op;
  logic [COORD_BITS-1:0]      cx, cy, cz;

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  // clamp count to store size, range checks
  assign count_eff = (XW'(point_count_q) > MaxX) ? MaxX : XW'(point_count_q);
  assign idx_x     = XW'(point_index_i);
  assign wr_ok     = (idx_x < MaxX);
  assign q_ok      = (idx_x < count_eff) && (count_eff >= XW'(2));

  // classify: writes out of range are dropped, bad queries answer empty
  always_comb begin
    if (func_i == bfnn_pkg::FUNC_QUERY) begin
      op = q_ok ? bfnn_pkg::OP_QUERY : bfnn_pkg::OP_EMPTY;
    end else begin
      op = bfnn_pkg::OP_WRITE;
    end
  end

  assign push_o = start_i && !full_i && ((func_i == bfnn_pkg::FUNC_QUERY) || wr_ok);

  // low coordinate bits, zero filled when the store is wider than the field
  assign cx = COORD_BITS'($unsigned(coord_x_i));
  assign cy = COORD_BITS'($unsigned(coord_y_i));
  assign cz = COORD_BITS'($unsigned(coord_z_i));

  assign entry_o = {op, AW'(point_index_i), CW'(count_eff), cx, cy, cz};

endmodule

// ===== rtl/bfnn_back.sv =====
// Back end: point store, query scan pipeline and result register
`include "brute_force_nearest_neighbor_unit_defines.svh"

module bfnn_back #(
  parameter int MAX_POINTS = bfnn_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = bfnn_pkg::COORD_BITS_DEF,
  parameter int AW         = $clog2(MAX_POINTS),
  parameter int CW         = $clog2(MAX_POINTS + 1),
  parameter int ENTRY_W    = bfnn_pkg::OP_W + AW + CW + 3 * COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ENTRY_W-1:0]            head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic                          found_o,
  output logic [bfnn_pkg::IDX_W-1:0]    neighbor_index_o,
  output logic [bfnn_pkg::DIST_W-1:0]   squared_distance_o
);

  localparam int CB = COORD_BITS;
  localparam int SW = 2 * CB;       // one squared axis difference
  localparam int DW = 2 * CB + 2;   // sum of three squares

  // entry field offsets
  localparam int Z_LO   = 0;
  localparam int Y_LO   = CB;
  localparam int X_LO   = 2 * CB;
  localparam int CNT_LO = 3 * CB;
  localparam int IDX_LO = 3 * CB + CW;
  localparam int OP_LO  = 3 * CB + CW + AW;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_QLAT  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  bfnn_pkg::op_e   h_op;
  logic [AW-1:0]   h_idx;
  logic [CW-1:0]   h_cnt;
  logic [CB-1:0]   h_x, h_y, h_z;

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   scan_i_q, scan_i_d;
  logic [AW-1:0]   qidx_q;
  logic [CW-1:0]   count_q;
  logic            take_query;
  logic            mem_we;
  logic [AW-1:0]   rd_addr;

  logic [CB-1:0]   x_mem [MAX_POINTS];
  logic [CB-1:0]   y_mem [MAX_POINTS];
  logic [CB-1:0]   z_mem [MAX_POINTS];
  logic [CB-1:0]   rx_q, ry_q, rz_q;
  logic [CB-1:0]   qx_q, qy_q, qz_q;

  logic            s1v_q, s1v_d;
  logic [AW-1:0]   s1i_q;
  logic            s2v_q;
  logic [AW-1:0]   s2i_q;
  logic [SW-1:0]   sqx_q, sqy_q, sqz_q;
  logic            s3v_q;
  logic [AW-1:0]   s3i_q;
  logic [DW-1:0]   sum_q;

  logic signed [CB:0]     dx, dy, dz;
  logic signed [2*CB+1:0] px, py, pz;

  logic            have_q;
  logic [AW-1:0]   best_i_q;
  logic [DW-1:0]   best_d_q;
  logic            better;

  logic            done_q, done_d;
  logic            found_q, found_d;
  logic [bfnn_pkg::IDX_W-1:0]  nidx_q, nidx_d;
  logic [bfnn_pkg::DIST_W-1:0] dist_q, dist_d;

  // unpack queue head
  assign h_op  = bfnn_pkg::op_e'(head_i[OP_LO +: bfnn_pkg::OP_W]);
  assign h_idx = head_i[IDX_LO +: AW];
  assign h_cnt = head_i[CNT_LO +: CW];
  assign h_x   = head_i[X_LO +: CB];
  assign h_y   = head_i[Y_LO +: CB];
  assign h_z   = head_i[Z_LO +: CB];

  assign pop_o      = (state_q == ST_IDLE) && !empty_i;
  assign mem_we     = pop_o && (h_op == bfnn_pkg::OP_WRITE);
  assign take_query = pop_o && (h_op == bfnn_pkg::OP_QUERY);
  assign rd_addr    = (state_q == ST_SCAN) ? scan_i_q : qidx_q;

  // sequencer and result staging
  always_comb begin
    state_d  = state_q;
    scan_i_d = scan_i_q;
    s1v_d    = 1'b0;
    done_d   = 1'b0;
    found_d  = found_q;
    nidx_d   = nidx_q;
    dist_d   = dist_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          unique case (h_op)
            bfnn_pkg::OP_QUERY: state_d = ST_LOAD;
            bfnn_pkg::OP_EMPTY: begin
              done_d  = 1'b1;
              found_d = 1'b0;
              nidx_d  = '0;
              dist_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: state_d = ST_QLAT;
      ST_QLAT: begin
        scan_i_d = '0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        s1v_d = (scan_i_q != qidx_q);
        if (CW'(scan_i_q) == count_q - CW'(1)) begin
          state_d = ST_DRAIN;
        end else begin
          scan_i_d = scan_i_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1v_q && !s2v_q && !s3v_q) begin
          done_d  = 1'b1;
          found_d = have_q;
          nidx_d  = have_q ? bfnn_pkg::IDX_W'(best_i_q) : '0;
          dist_d  = have_q ? bfnn_pkg::DIST_W'(best_d_q) : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s1v_q   <= 1'b0;
      s2v_q   <= 1'b0;
      s3v_q   <= 1'b0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      s1v_q   <= s1v_d;
      s2v_q   <= s1v_q;
      s3v_q   <= s2v_q;
      done_q  <= done_d;
      if (state_q == ST_QLAT) begin
        have_q <= 1'b0;
      end else if (better) begin
        have_q <= 1'b1;
      end
    end
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      x_mem[h_idx] <= h_x;
      y_mem[h_idx] <= h_y;
      z_mem[h_idx] <= h_z;
    end
    rx_q <= x_mem[rd_addr];
    ry_q <= y_mem[rd_addr];
    rz_q <= z_mem[rd_addr];
  end

  // axis differences and squares
  assign dx = $signed({rx_q[CB-1], rx_q}) - $signed({qx_q[CB-1], qx_q});
  assign dy = $signed({ry_q[CB-1], ry_q}) - $signed({qy_q[CB-1], qy_q});
  assign dz = $signed({rz_q[CB-1], rz_q}) - $signed({qz_q[CB-1], qz_q});
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // strict compare keeps the lower index on ties
  assign better = s3v_q && (!have_q || (sum_q < best_d_q));

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_query) begin
      qidx_q  <= h_idx;
      count_q <= h_cnt;
    end
    if (state_q == ST_QLAT) begin
      qx_q <= rx_q;
      qy_q <= ry_q;
      qz_q <= rz_q;
    end
    scan_i_q <= scan_i_d;
    s1i_q    <= scan_i_q;
    s2i_q    <= s1i_q;
    sqx_q    <= px[SW-1:0];
    sqy_q    <= py[SW-1:0];
    sqz_q    <= pz[SW-1:0];
    s3i_q    <= s2i_q;
    sum_q    <= DW'(sqx_q) + DW'(sqy_q) + DW'(sqz_q);
    if (better) begin
      best_i_q <= s3i_q;
      best_d_q <= sum_q;
    end
    found_q <= found_d;
    nidx_q  <= nidx_d;
    dist_q  <= dist_d;
  end

  assign done_o             = done_q;
  assign found_o            = found_q;
  assign neighbor_index_o   = nidx_q;
  assign squared_distance_o = dist_q;

  `BFNN_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, state_q == ST_SCAN, CW'(scan_i_q) < count_q, "scan index past count")
  `BFNN_ASSERT_IMP(a_pipe_in_query, clk_i, rst_ni, s3v_q, (state_q == ST_SCAN) || (state_q == ST_DRAIN), "compare outside query")
  `BFNN_ASSERT_IMP(a_not_self, clk_i, rst_ni, done_q && found_q, best_i_q != qidx_q, "query point chosen as neighbor")
  `BFNN_ASSERT_NXT(a_found_only_drain, clk_i, rst_ni, (state_q != ST_DRAIN) && (state_d == ST_IDLE) && done_d, !found_q, "found reported for empty query")

endmodule

// ===== bench/nn_search_checker.sv =====
// Scoreboard for the nearest neighbor unit: mirrors the point store, predicts and checks results
`timescale 1ns / 100ps

module nn_search_checker
  import bfnn_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CNT_W-1:0]           cfg_wdata_i,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       func_i,
  input  logic [IDX_W-1:0]           point_index_i,
  input  logic signed [FIELD_W-1:0]  coord_x_i,
  input  logic signed [FIELD_W-1:0]  coord_y_i,
  input  logic signed [FIELD_W-1:0]  coord_z_i,
  input  logic                       done_i,
  input  logic                       found_i,
  input  logic [IDX_W-1:0]           neighbor_index_i,
  input  logic [DIST_W-1:0]          squared_distance_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);

  typedef logic signed [FIELD_W-1:0] coord_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  neighbor;
    logic [DIST_W-1:0] sq_dist;
  } neighbor_t;

  // shadow copy of the point store and the count register
  coord_t           px [MAX_POINTS];
  coord_t           py [MAX_POINTS];
  coord_t           pz [MAX_POINTS];
  logic [CNT_W-1:0] point_count;

  neighbor_t nearest_q [$];
  neighbor_t oldest;
  int        mismatches;

  // full scan of the live points; strict less-than keeps the lower index on ties
  function automatic neighbor_t nearest_to(input logic [IDX_W-1:0] slot);
    neighbor_t         best;
    int                live;
    longint            dx, dy, dz;
    logic [DIST_W-1:0] d;
    best = '0;
    live = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
    if (slot < live) begin
      for (int i = 0; i < live; i++) begin
        if (i != slot) begin
          dx = longint'(px[i]) - longint'(px[slot]);
          dy = longint'(py[i]) - longint'(py[slot]);
          dz = longint'(pz[i]) - longint'(pz[slot]);
          d  = DIST_W'(dx * dx + dy * dy + dz * dz);
          if (!best.found || d < best.sq_dist) begin
            best.found    = 1'b1;
            best.neighbor = i[IDX_W-1:0];
            best.sq_dist  = d;
          end
        end
      end
    end
    return best;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      point_count = '0;
      nearest_q.delete();
      mismatches = 0;
    end else begin
      // result side: each done pulse retires the oldest query
      if (done_i) begin
        if (nearest_q.size() == 0) begin
          $error("unexpected result: found %0d, neighbor_index %0d, squared_distance %0d",
                 found_i, neighbor_index_i, squared_distance_i);
          mismatches++;
        end else begin
          oldest = nearest_q.pop_front();
          if (found_i !== oldest.found) begin
            $error("found: expected %0d, actual %0d", oldest.found, found_i);
            mismatches++;
          end
          if (neighbor_index_i !== oldest.neighbor) begin
            $error("neighbor_index: expected %0d, actual %0d", oldest.neighbor,
                   neighbor_index_i);
            mismatches++;
          end
          if (squared_distance_i !== oldest.sq_dist) begin
            $error("squared_distance: expected %0d, actual %0d", oldest.sq_dist,
                   squared_distance_i);
            mismatches++;
          end
        end
      end

      if (cfg_we_i) point_count = cfg_wdata_i;

      // command side: writes update the shadow store, queries queue a prediction
      if (start_i && !busy_i) begin
        if (func_i == FUNC_QUERY) begin
          nearest_q.insert(nearest_q.size(), nearest_to(point_index_i));
        end else if (point_index_i < MAX_POINTS) begin
          px[point_index_i] = coord_x_i;
          py[point_index_i] = coord_y_i;
          pz[point_index_i] = coord_z_i;
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= nearest_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Bench top for the nearest neighbor unit: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import bfnn_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 20000;
  localparam int PHASES        = 12;
  localparam int FILL_POINTS   = 256;

  typedef logic signed [FIELD_W-1:0] coord_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              start;
  logic              busy;
  logic              func;
  logic [IDX_W-1:0]  point_index;
  coord_t            coord_x, coord_y, coord_z;
  logic              done;
  logic              found;
  logic [IDX_W-1:0]  neighbor_index;
  logic [DIST_W-1:0] squared_distance;

  int mismatch_count;
  int results_pending;
  int point_count_now;
  int idle_pct;
  int stall_cycles;

  brute_force_nearest_neighbor_unit u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .start_i            (start),
    .busy_o             (busy),
    .func_i             (func),
    .point_index_i      (point_index),
    .coord_x_i          (coord_x),
    .coord_y_i          (coord_y),
    .coord_z_i          (coord_z),
    .done_o             (done),
    .found_o            (found),
    .neighbor_index_o   (neighbor_index),
    .squared_distance_o (squared_distance)
  );

  nn_search_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .start_i            (start),
    .busy_i             (busy),
    .func_i             (func),
    .point_index_i      (point_index),
    .coord_x_i          (coord_x),
    .coord_y_i          (coord_y),
    .coord_z_i          (coord_z),
    .done_i             (done),
    .found_i            (found),
    .neighbor_index_i   (neighbor_index),
    .squared_distance_i (squared_distance),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: too long without a word taken or a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[brute_force_nearest_neighbor_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one command word, with random gaps and the odd pause until all results are back
  task automatic send_word(input logic f, input logic [IDX_W-1:0] idx,
                           input coord_t x, input coord_t y, input coord_t z);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    if ($urandom_range(0, 59) == 0) begin
      start <= 1'b0;
      do @(posedge clk); while (results_pending != 0);
    end
    start       <= 1'b1;
    func        <= f;
    point_index <= idx;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // idle the command side until every query has answered and trailing writes are done
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_point_count(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    point_count_now = value;
  endtask

  // 0: full range, 1: tight cluster around the origin (ties, zero distance), else corners
  function automatic coord_t pick_coord(input int style);
    case (style)
      0: return coord_t'($urandom_range(0, 65535));
      1: return coord_t'(int'($urandom_range(0, 4)) - 2);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  task automatic write_random_point(input logic [IDX_W-1:0] idx);
    int style;
    style = $urandom_range(0, 2);
    send_word(FUNC_WRITE, idx, pick_coord(style), pick_coord(style), pick_coord(style));
  endtask

  initial begin
    int new_count;
    int items;
    int live_points;
    int pick;
    start       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    func        <= FUNC_WRITE;
    point_index <= '0;
    coord_x     <= '0;
    coord_y     <= '0;
    coord_z     <= '0;
    rst_n       <= 1'b0;
    idle_pct = 0;
    point_count_now = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty cloud straight out of reset
    send_word(FUNC_QUERY, 10'd0, '0, '0, '0);
    send_word(FUNC_QUERY, 10'd1023, '0, '0, '0);
    send_word(FUNC_WRITE, 10'd0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(FUNC_WRITE, 10'd1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(FUNC_WRITE, 10'd2, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(FUNC_WRITE, 10'd3, 16'sh0001, 16'sh0000, 16'sh0000);
    send_word(FUNC_WRITE, 10'd4, 16'sh0000, 16'shffff, 16'sh0000);
    send_word(FUNC_WRITE, 10'd5, 16'sh0000, 16'sh0000, 16'sh0001);

    // lone point, then a query past the count
    set_point_count(1);
    send_word(FUNC_QUERY, 10'd0, '0, '0, '0);
    send_word(FUNC_QUERY, 10'd1, '0, '0, '0);

    // opposite corners: largest possible distance
    set_point_count(2);
    send_word(FUNC_QUERY, 10'd0, '0, '0, '0);
    send_word(FUNC_QUERY, 10'd1, '0, '0, '0);

    // three-way tie, query after overwrite, duplicate point
    set_point_count(6);
    send_word(FUNC_QUERY, 10'd2, '0, '0, '0);
    send_word(FUNC_QUERY, 10'd5, '0, '0, '0);
    send_word(FUNC_QUERY, 10'd6, '0, '0, '0);
    send_word(FUNC_WRITE, 10'd3, 16'sh8000, 16'sh7fff, 16'sh0000);
    send_word(FUNC_QUERY, 10'd2, '0, '0, '0);
    send_word(FUNC_WRITE, 10'd6, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(FUNC_WRITE, 10'd5, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(FUNC_QUERY, 10'd2, '0, '0, '0);

    // fill the low slots; every count used below stays inside them
    idle_pct = 29;
    for (int i = 0; i < FILL_POINTS; i++) begin
      write_random_point(i[IDX_W-1:0]);
    end

    // random phases: mostly small clouds, a few larger scans
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin new_count = 2;   items = 40; end
        1:       begin new_count = 7;   items = 40; end
        2:       begin new_count = 16;  items = 40; end
        3:       begin new_count = 0;   items = 15; end
        4:       begin new_count = 64;  items = 30; end
        5:       begin new_count = 1;   items = 15; end
        6:       begin new_count = 256; items = 8;  end
        7:       begin new_count = 3;   items = 40; end
        8:       begin new_count = 31;  items = 40; end
        9:       begin new_count = 200; items = 8;  end
        10:      begin new_count = 128; items = 20; end
        default: begin new_count = 9;   items = 10; end
      endcase
      set_point_count(new_count);
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 48 : 29;
      live_points = (point_count_now > MAX_POINTS_DEF) ? MAX_POINTS_DEF : point_count_now;
      for (int n = 0; n < items; n++) begin
        if ($urandom_range(0, 1) == 1) begin
          // queries land mostly on live slots, some anywhere
          pick = (live_points == 0 || $urandom_range(0, 9) == 0) ?
                 $urandom_range(0, 1023) : $urandom_range(0, live_points - 1);
          send_word(FUNC_QUERY, pick[IDX_W-1:0], pick_coord(0), pick_coord(0),
                    pick_coord(0));
        end else begin
          pick = (live_points == 0 || $urandom_range(0, 3) == 0) ?
                 $urandom_range(0, 1023) : $urandom_range(0, live_points - 1);
          write_random_point(pick[IDX_W-1:0]);
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("[brute_force_nearest_neighbor_unit] OK");
    end else begin
      $display("[brute_force_nearest_neighbor_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bfnn_pkg.sv
rtl/bfnn_fifo.sv
rtl/bfnn_front.sv
rtl/bfnn_back.sv
rtl/brute_force_nearest_neighbor_unit.sv
bench/nn_search_checker.sv
bench/testbench.sv
